// ----- rtl/core/bqnx_pkg.sv -----
// Shared types, constants and saturation helpers for the biquad notch with crossfade.
// Used by the controller, the datapath, the divider and the top level.
package bqnx_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 24;
	localparam int COEF_FRAC = 20;
	localparam int W_FRAC    = 8;
	localparam int STATE_W   = 32;
	localparam int LEN_W     = 9;
	localparam int MAX_FRAME = 480;
	localparam int MODE_W    = 2;

	localparam int PROD_W = COEF_W + STATE_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int Q_W    = STATE_W + 1;

	// |num*f + (den-num)*dry| stays below MAX_FRAME * 2^31
	localparam int DIV_W      = 40;
	localparam int DIV_STEP   = 4;
	localparam int DIV_ITERS  = DIV_W / DIV_STEP;
	localparam int DIV_CNT_W  = $clog2(DIV_ITERS);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_B0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B1  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A1  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A2  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LEN = 3'd5;

	localparam logic [MODE_W-1:0] FADE_PLAIN = 2'd0;
	localparam logic [MODE_W-1:0] FADE_OUT   = 2'd1;
	localparam logic [MODE_W-1:0] FADE_IN    = 2'd2;

	localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC);
	localparam logic [LEN_W-1:0]         LEN_RST  = LEN_W'(MAX_FRAME);

	// multiplier operand pairs
	localparam logic [2:0] MUL_A1W1 = 3'd0;
	localparam logic [2:0] MUL_A2W2 = 3'd1;
	localparam logic [2:0] MUL_B1W1 = 3'd2;
	localparam logic [2:0] MUL_B2W2 = 3'd3;
	localparam logic [2:0] MUL_B0W  = 3'd4;
	localparam logic [2:0] MUL_DRY  = 3'd5;
	localparam logic [2:0] MUL_NUMF = 3'd6;

	// accumulator operations
	localparam logic [2:0] ACC_HOLD    = 3'd0;
	localparam logic [2:0] ACC_LD_X    = 3'd1;
	localparam logic [2:0] ACC_LD_RND  = 3'd2;
	localparam logic [2:0] ACC_LD_ZERO = 3'd3;
	localparam logic [2:0] ACC_ADD     = 3'd4;
	localparam logic [2:0] ACC_SUB     = 3'd5;

	typedef struct packed {
		logic       ld_in;
		logic [2:0] mul_sel;
		logic [2:0] acc_op;
		logic       ld_w;
		logic       ld_f;
		logic       div_start;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic bypass;
		logic blend;
		logic div_done;
	} dp_sts_t;

	// Round-shifted accumulator (rounding constant already added) to signed 32 bit.
	function automatic logic signed [STATE_W-1:0] sat_acc(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] sh;
		logic                    fits;
		sh = a >>> COEF_FRAC;
		fits = (&sh[ACC_W-1:STATE_W-1]) | (~|sh[ACC_W-1:STATE_W-1]);
		if (fits)
			return sh[STATE_W-1:0];
		else if (sh[ACC_W-1])
			return {1'b1, {(STATE_W-1){1'b0}}};
		else
			return {1'b0, {(STATE_W-1){1'b1}}};
	endfunction

	// Round away the W fraction bits and clamp to the sample range.
	function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [Q_W-1:0] q);
		logic signed [Q_W:0] sum;
		logic signed [Q_W:0] sh;
		logic                fits;
		sum = {q[Q_W-1], q} + (Q_W+1)'(1 << (W_FRAC-1));
		sh = sum >>> W_FRAC;
		fits = (&sh[Q_W:SAMPLE_W-1]) | (~|sh[Q_W:SAMPLE_W-1]);
		if (fits)
			return sh[SAMPLE_W-1:0];
		else if (sh[Q_W])
			return {1'b1, {(SAMPLE_W-1){1'b0}}};
		else
			return {1'b0, {(SAMPLE_W-1){1'b1}}};
	endfunction

endpackage

// ----- rtl/core/bqnx_div.sv -----
// Iterative unsigned restoring divider, DIV_STEP quotient bits per cycle,
// with sign applied at the end (truncation toward zero). Depends on bqnx_pkg.
module bqnx_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          neg,
	input  logic [bqnx_pkg::DIV_W-1:0]    dividend,
	input  logic [bqnx_pkg::LEN_W-1:0]    divisor,
	output logic                          done,
	output logic signed [bqnx_pkg::Q_W-1:0] quotient
);
	import bqnx_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     dvd_q;
	logic [LEN_W-1:0]     rem_q;
	logic [LEN_W-1:0]     den_q;
	logic                 neg_q;
	logic [DIV_W-1:0]     dvd_d;
	logic [LEN_W-1:0]     rem_d;

	always_comb begin
		logic [LEN_W:0] trial;
		dvd_d = dvd_q;
		rem_d = rem_q;
		for (int k = 0; k < DIV_STEP; k++) begin
			trial = {rem_d, dvd_d[DIV_W-1]};
			dvd_d = {dvd_d[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_d    = LEN_W'(trial - {1'b0, den_q});
				dvd_d[0] = 1'b1;
			end else begin
				rem_d = trial[LEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == DIV_CNT_W'(DIV_ITERS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_ITERS - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
			neg_q <= neg;
		end else if (busy_q) begin
			dvd_q <= dvd_d;
			rem_q <= rem_d;
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -Q_W'(dvd_q) : Q_W'(dvd_q);

endmodule

// ----- rtl/core/bqnx_datapath.sv -----
// Datapath: coefficient registers, delay line, frame counter, shared 24x32
// multiplier with accumulator, blend divider and output register. Depends on bqnx_pkg, bqnx_div.
module bqnx_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bqnx_pkg::dp_cmd_t                   cmd,
	output bqnx_pkg::dp_sts_t                   sts,
	input  logic                                cfg_wr,
	input  logic [bqnx_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bqnx_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic signed [bqnx_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [bqnx_pkg::MODE_W-1:0]         fade_mode,
	output logic signed [bqnx_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                frame_end
);
	import bqnx_pkg::*;

	logic signed [COEF_W-1:0]  b0_q, b1_q, b2_q, a1_q, a2_q;
	logic [LEN_W-1:0]          frame_len_q;
	logic signed [STATE_W-1:0] delay_one_q, delay_two_q;
	logic [LEN_W-1:0]          frame_pos_q;

	logic signed [SAMPLE_W-1:0] x_q;
	logic                       blend_q, bypass_q, end_q;
	logic [LEN_W-1:0]           pos_q, num_q, dnum_q, den_q;
	logic signed [STATE_W-1:0]  w_q, f_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic                       frame_end_q;

	logic                      bad_len;
	logic [LEN_W-1:0]          pos_eff, half, num_d, den_d;
	logic signed [COEF_W-1:0]  mul_a;
	logic signed [STATE_W-1:0] mul_b;
	logic                      p_neg;
	logic signed [ACC_W-1:0]   p_mag;
	logic                      div_done;
	logic signed [Q_W-1:0]     div_q;
	logic signed [Q_W-1:0]     q_sel;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q        <= COEF_ONE;
			b1_q        <= '0;
			b2_q        <= '0;
			a1_q        <= '0;
			a2_q        <= '0;
			frame_len_q <= LEN_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_B0:  b0_q        <= cfg_data;
				REG_B1:  b1_q        <= cfg_data;
				REG_B2:  b2_q        <= cfg_data;
				REG_A1:  a1_q        <= cfg_data;
				REG_A2:  a2_q        <= cfg_data;
				REG_LEN: frame_len_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// frame position and fade weights for the incoming sample
	always_comb begin
		bad_len = (frame_len_q == '0) || (frame_len_q > LEN_W'(MAX_FRAME));
		pos_eff = (frame_pos_q >= frame_len_q) ? '0 : frame_pos_q;
		half    = frame_len_q >> 1;
		if (fade_mode == FADE_OUT) begin
			den_d = frame_len_q;
			num_d = frame_len_q - pos_eff;
		end else begin
			den_d = frame_len_q - half;
			num_d = (pos_eff > half) ? pos_eff - half : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= 1'b0;
			blend_q  <= 1'b0;
		end else if (cmd.ld_in) begin
			bypass_q <= bad_len;
			blend_q  <= (fade_mode == FADE_OUT) || (fade_mode == FADE_IN);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			x_q    <= sample_in;
			pos_q  <= pos_eff;
			end_q  <= (pos_eff == frame_len_q - 1'b1);
			num_q  <= num_d;
			den_q  <= den_d;
			dnum_q <= den_d - num_d;
		end
	end

	// shared multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			MUL_A1W1: begin mul_a = a1_q; mul_b = delay_one_q; end
			MUL_A2W2: begin mul_a = a2_q; mul_b = delay_two_q; end
			MUL_B1W1: begin mul_a = b1_q; mul_b = delay_one_q; end
			MUL_B2W2: begin mul_a = b2_q; mul_b = delay_two_q; end
			MUL_B0W:  begin mul_a = b0_q; mul_b = w_q; end
			MUL_DRY: begin
				mul_a = COEF_W'(dnum_q);
				mul_b = {{(STATE_W-SAMPLE_W-W_FRAC){x_q[SAMPLE_W-1]}}, x_q, {W_FRAC{1'b0}}};
			end
			MUL_NUMF: begin mul_a = COEF_W'(num_q); mul_b = f_q; end
			default:  begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (cmd.acc_op)
			ACC_LD_X: acc_q <= {{(ACC_W-SAMPLE_W-COEF_FRAC-W_FRAC){x_q[SAMPLE_W-1]}}, x_q,
				{(COEF_FRAC+W_FRAC){1'b0}}} + ACC_W'(1 << (COEF_FRAC-1));
			ACC_LD_RND:  acc_q <= ACC_W'(1 << (COEF_FRAC-1));
			ACC_LD_ZERO: acc_q <= '0;
			ACC_ADD:     acc_q <= acc_q + ACC_W'(prod_q);
			ACC_SUB:     acc_q <= acc_q - ACC_W'(prod_q);
			default:     acc_q <= acc_q;
		endcase
		if (cmd.ld_w)
			w_q <= sat_acc(acc_q);
		if (cmd.ld_f)
			f_q <= sat_acc(acc_q);
	end

	// blend quotient: magnitude division, sign restored after
	assign p_neg = acc_q[ACC_W-1];
	assign p_mag = p_neg ? -acc_q : acc_q;

	bqnx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.neg      (p_neg),
		.dividend (p_mag[DIV_W-1:0]),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (div_q)
	);

	assign q_sel = blend_q ? div_q : {f_q[STATE_W-1], f_q};

	// commit delay line and frame position with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_one_q <= '0;
			delay_two_q <= '0;
			frame_pos_q <= '0;
		end else if (cmd.out_load && !bypass_q) begin
			delay_two_q <= delay_one_q;
			delay_one_q <= w_q;
			frame_pos_q <= end_q ? '0 : pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sample_out_q <= bypass_q ? x_q : sat_out(q_sel);
			frame_end_q  <= !bypass_q && end_q;
		end
	end

	assign sts.bypass   = bypass_q;
	assign sts.blend    = blend_q;
	assign sts.div_done = div_done;
	assign sample_out   = sample_out_q;
	assign frame_end    = frame_end_q;

endmodule

// ----- rtl/core/bqnx_ctrl.sv -----
// Controller: sequences the multiply-accumulate program, the blend division
// and the output handshake. Depends on bqnx_pkg.
module bqnx_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output bqnx_pkg::dp_cmd_t cmd,
	input  bqnx_pkg::dp_sts_t sts
);
	import bqnx_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_FB0  = 4'd1;
	localparam logic [3:0] ST_FB1  = 4'd2;
	localparam logic [3:0] ST_FB2  = 4'd3;
	localparam logic [3:0] ST_FF0  = 4'd4;
	localparam logic [3:0] ST_FF1  = 4'd5;
	localparam logic [3:0] ST_FF2  = 4'd6;
	localparam logic [3:0] ST_FF3  = 4'd7;
	localparam logic [3:0] ST_BL0  = 4'd8;
	localparam logic [3:0] ST_BL1  = 4'd9;
	localparam logic [3:0] ST_BL2  = 4'd10;
	localparam logic [3:0] ST_DIVS = 4'd11;
	localparam logic [3:0] ST_DIV  = 4'd12;
	localparam logic [3:0] ST_OUT  = 4'd13;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					state_d   = ST_FB0;
				end
			end
			// feedback: w = x - a1*w1 - a2*w2
			ST_FB0: begin
				cmd.acc_op  = ACC_LD_X;
				cmd.mul_sel = MUL_A1W1;
				state_d     = sts.bypass ? ST_OUT : ST_FB1;
			end
			ST_FB1: begin
				cmd.acc_op  = ACC_SUB;
				cmd.mul_sel = MUL_A2W2;
				state_d     = ST_FB2;
			end
			ST_FB2: begin
				cmd.acc_op = ACC_SUB;
				state_d    = ST_FF0;
			end
			// feedforward: f = b0*w + b1*w1 + b2*w2
			ST_FF0: begin
				cmd.ld_w    = 1'b1;
				cmd.acc_op  = ACC_LD_RND;
				cmd.mul_sel = MUL_B1W1;
				state_d     = ST_FF1;
			end
			ST_FF1: begin
				cmd.acc_op  = ACC_ADD;
				cmd.mul_sel = MUL_B2W2;
				state_d     = ST_FF2;
			end
			ST_FF2: begin
				cmd.acc_op  = ACC_ADD;
				cmd.mul_sel = MUL_B0W;
				state_d     = ST_FF3;
			end
			ST_FF3: begin
				cmd.acc_op = ACC_ADD;
				state_d    = ST_BL0;
			end
			ST_BL0: begin
				cmd.ld_f = 1'b1;
				if (sts.blend) begin
					cmd.acc_op  = ACC_LD_ZERO;
					cmd.mul_sel = MUL_DRY;
					state_d     = ST_BL1;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_BL1: begin
				cmd.acc_op  = ACC_ADD;
				cmd.mul_sel = MUL_NUMF;
				state_d     = ST_BL2;
			end
			ST_BL2: begin
				cmd.acc_op = ACC_ADD;
				state_d    = ST_DIVS;
			end
			ST_DIVS: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the wait state");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_FB0)
		else $error("accepted transfer did not start the program");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid_q || out_ready)
		else $error("output register overwritten before transfer");

endmodule

// ----- rtl/core/biquad_notch_with_crossfade.sv -----
// Top level of the direct-form-II biquad notch with frame crossfade.
// Depends on bqnx_pkg, bqnx_ctrl, bqnx_datapath (which holds bqnx_div).
//
// One sample is processed at a time. After the input transfer a plain-filter
// sample runs the filter program; a fade-out or fade-in sample also runs the
// blend and the division, and a pass-through sample (frame length 0 or above
// 480) skips both. The single shared 24x32 multiplier forms the five filter
// products one per cycle, and the blend divider produces four quotient bits
// per cycle. The result sits in an output register, so the next sample is
// accepted while it waits; a new result is held back only if the previous
// one is still there.
// Configuration writes are always taken and must be issued while idle.
module biquad_notch_with_crossfade (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [bqnx_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [bqnx_pkg::MODE_W-1:0]          fade_mode,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [bqnx_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                 frame_end,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bqnx_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bqnx_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import bqnx_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	bqnx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	bqnx_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_wr     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample_in  (sample_in),
		.fade_mode  (fade_mode),
		.sample_out (sample_out),
		.frame_end  (frame_end)
	);

endmodule

// ----- bench/tb_biquad_notch_with_crossfade.sv -----
`timescale 1ns / 1ps
// Self-checking bench for biquad_notch_with_crossfade: corner samples, then random frames under
// several coefficient sets and frame lengths, checked against an in-bench fixed-point predictor.
// Depends on bqnx_pkg and the biquad_notch_with_crossfade top level.
module tb_biquad_notch_with_crossfade;
	import bqnx_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 400;
	localparam int MAX_REPORTS  = 10;
	localparam logic [MODE_W-1:0] FADE_UNDEF = 2'd3;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [MODE_W-1:0]          mode;
	} audio_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       frame_end;
	} audio_result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic                       clk        = 1'b0;
	logic                       arst_n     = 1'b0;
	logic                       in_valid   = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample_in  = '0;
	logic [MODE_W-1:0]          fade_mode  = FADE_PLAIN;
	logic                       out_valid;
	logic                       out_ready  = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       frame_end;
	logic                       cfg_valid  = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index  = '0;
	logic [CFG_DATA_W-1:0]      cfg_data   = '0;

	audio_item_t   sample_q[$];
	audio_result_t filtered_q[$];
	reg_write_t    reg_write_q[$];

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   mismatch_cnt  = 0;
	int   cycle_cnt     = 0;
	bit   hold_go       = 1'b0;
	logic rx_hold_off   = 1'b0;

	// filter registers and history as the block should hold them
	logic signed [COEF_W-1:0]  b0_m = COEF_ONE;
	logic signed [COEF_W-1:0]  b1_m = '0;
	logic signed [COEF_W-1:0]  b2_m = '0;
	logic signed [COEF_W-1:0]  a1_m = '0;
	logic signed [COEF_W-1:0]  a2_m = '0;
	logic [LEN_W-1:0]          len_m = LEN_RST;
	logic signed [STATE_W-1:0] w1_m = '0;
	logic signed [STATE_W-1:0] w2_m = '0;
	logic [LEN_W-1:0]          pos_m = '0;

	biquad_notch_with_crossfade u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_in (sample_in),
		.fade_mode (fade_mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample_out(sample_out),
		.frame_end (frame_end),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// add half an LSB, then floor
	function automatic longint round_down(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	// One biquad step plus crossfade; advances the history and frame position.
	function automatic audio_result_t biquad_predict(input audio_item_t it);
		audio_result_t r;
		longint x, len, idx, w1, w2, acc, w, f, q, num, den, dry;
		x = it.sample;
		len = len_m;
		r.frame_end = 1'b0;
		r.sample = it.sample;
		if (len == 0 || len > MAX_FRAME)
			return r;
		idx = pos_m;
		if (idx >= len)
			idx = 0;
		w1 = w1_m;
		w2 = w2_m;
		acc = (x <<< (COEF_FRAC + W_FRAC)) - longint'(a1_m) * w1 - longint'(a2_m) * w2;
		w = clamp(round_down(acc, COEF_FRAC), S32_MIN, S32_MAX);
		acc = longint'(b0_m) * w + longint'(b1_m) * w1 + longint'(b2_m) * w2;
		f = clamp(round_down(acc, COEF_FRAC), S32_MIN, S32_MAX);
		q = f;
		if (it.mode == FADE_OUT || it.mode == FADE_IN) begin
			dry = x <<< W_FRAC;
			if (it.mode == FADE_OUT) begin
				num = len - idx;
				den = len;
			end else begin
				den = len - len / 2;
				num = (idx > len / 2) ? idx - len / 2 : 0;
			end
			q = (num * f + (den - num) * dry) / den;
		end
		r.sample = SAMPLE_W'(clamp(round_down(q, W_FRAC), -32768, 32767));
		r.frame_end = (idx == len - 1);
		w2_m = w1_m;
		w1_m = STATE_W'(w);
		pos_m = (idx == len - 1) ? '0 : LEN_W'(idx + 1);
		return r;
	endfunction

	function automatic void flag_mismatch(input bit have_exp, input audio_result_t exp_r);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS) begin
			if (have_exp)
				$display("[%0t] mismatch: expected sample %0d frame_end %0b, got sample %0d frame_end %0b",
					$time, $signed(exp_r.sample), exp_r.frame_end, $signed(sample_out), frame_end);
			else
				$display("[%0t] mismatch: unexpected result sample %0d frame_end %0b",
					$time, $signed(sample_out), frame_end);
		end
	endfunction

	// sample driver: hold the offered item until it transfers, then load the next or idle
	always @(posedge clk) begin
		audio_item_t cur;
		audio_item_t nxt;
		if (in_valid && in_ready) begin
			cur.sample = sample_in;
			cur.mode = fade_mode;
			filtered_q.push_back(biquad_predict(cur));
		end
		if (arst_n && !(in_valid && !in_ready)) begin
			if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = sample_q.pop_front();
				in_valid <= 1'b1;
				sample_in <= nxt.sample;
				fade_mode <= nxt.mode;
			end else
				in_valid <= 1'b0;
		end
	end

	// register write driver; the shadow copy follows each transfer
	always @(posedge clk) begin
		reg_write_t wr;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_B0: b0_m = cfg_data;
				REG_B1: b1_m = cfg_data;
				REG_B2: b2_m = cfg_data;
				REG_A1: a1_m = cfg_data;
				REG_A2: a2_m = cfg_data;
				REG_LEN: len_m = cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
		if (arst_n && !(cfg_valid && !cfg_ready)) begin
			if (reg_write_q.size() != 0) begin
				wr = reg_write_q.pop_front();
				cfg_valid <= 1'b1;
				cfg_index <= wr.index;
				cfg_data <= wr.data;
			end else
				cfg_valid <= 1'b0;
		end
	end

	// result monitor
	always @(posedge clk) begin
		audio_result_t exp_r;
		if (out_valid && out_ready) begin
			if (filtered_q.size() == 0) begin
				exp_r = '0;
				flag_mismatch(1'b0, exp_r);
			end else begin
				exp_r = filtered_q.pop_front();
				if (sample_out !== exp_r.sample || frame_end !== exp_r.frame_end)
					flag_mismatch(1'b1, exp_r);
			end
		end
		if (arst_n)
			out_ready <= !rx_hold_off && ($urandom_range(99) >= recv_idle_pct);
	end

	// long receiver stall so the output register fills and the input backs up
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("biquad_notch_with_crossfade regression: fail");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		reg_write_t wr;
		wr.index = idx;
		wr.data = data;
		reg_write_q.push_back(wr);
	endtask

	task automatic queue_sample(input logic signed [SAMPLE_W-1:0] s, input logic [MODE_W-1:0] m);
		audio_item_t it;
		it.sample = s;
		it.mode = m;
		sample_q.push_back(it);
	endtask

	// wait until every write and sample has transferred and every result is back
	task automatic settle();
		do
			@(negedge clk);
		while (reg_write_q.size() != 0 || cfg_valid || sample_q.size() != 0 || in_valid
			|| filtered_q.size() != 0 || in_ready !== 1'b1);
	endtask

	task automatic queue_random(input int n);
		int r;
		logic [MODE_W-1:0] m;
		logic signed [SAMPLE_W-1:0] s;
		repeat (n) begin
			r = $urandom_range(0, 9);
			m = (r < 3) ? FADE_PLAIN : (r < 6) ? FADE_OUT : (r < 9) ? FADE_IN : FADE_UNDEF;
			case ($urandom_range(0, 15))
				0: s = 16'sh7fff;
				1: s = 16'sh8000;
				2, 3: s = SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
				default: s = SAMPLE_W'($urandom);
			endcase
			queue_sample(s, m);
		end
	endtask

	// stable sets keep both poles inside the unit circle; the rest are raw 24-bit words
	task automatic load_filter(input bit stable, input logic [LEN_W-1:0] len);
		int a1, a2, lim;
		if (stable) begin
			a2 = $urandom_range(0, 996000);
			lim = (1 << COEF_FRAC) + a2 - 1;
			a1 = int'($urandom_range(0, 2 * lim)) - lim;
			write_reg(REG_B0, CFG_DATA_W'($urandom_range(262144, 1048576)));
			write_reg(REG_B1, CFG_DATA_W'(int'($urandom_range(0, 1 << 22)) - (1 << 21)));
			write_reg(REG_B2, CFG_DATA_W'($urandom_range(262144, 1048576)));
			write_reg(REG_A1, CFG_DATA_W'(a1));
			write_reg(REG_A2, CFG_DATA_W'(a2));
		end else begin
			write_reg(REG_B0, CFG_DATA_W'($urandom));
			write_reg(REG_B1, CFG_DATA_W'($urandom));
			write_reg(REG_B2, CFG_DATA_W'($urandom));
			write_reg(REG_A1, CFG_DATA_W'($urandom));
			write_reg(REG_A2, CFG_DATA_W'($urandom));
		end
		// upper data bits are don't-care for the length register
		write_reg(REG_LEN, {15'($urandom), len});
		settle();
	endtask

	initial begin
		send_idle_pct = 25;
		recv_idle_pct = 87;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset coefficients: unity filter, every fade mode
		queue_sample(16'sh7fff, FADE_PLAIN);
		queue_sample(16'sh8000, FADE_PLAIN);
		queue_sample(16'sh0000, FADE_OUT);
		queue_sample(16'sh0001, FADE_IN);
		queue_sample(-16'sd1, FADE_UNDEF);
		settle();

		// frame shorter than the current position, full-scale taps to force saturation
		write_reg(REG_B0, 24'h7fffff);
		write_reg(REG_B1, 24'h800000);
		write_reg(REG_B2, 24'h7fffff);
		write_reg(REG_A1, 24'h800000);
		write_reg(REG_A2, 24'h7fffff);
		write_reg(REG_LEN, 24'd3);
		settle();
		queue_sample(16'sh7fff, FADE_OUT);
		queue_sample(16'sh8000, FADE_IN);
		queue_sample(16'sh7fff, FADE_PLAIN);
		queue_sample(16'sh8000, FADE_OUT);
		queue_sample(16'sd12345, FADE_IN);
		queue_sample(-16'sd1, FADE_PLAIN);
		settle();

		// illegal frame lengths pass the sample through untouched
		write_reg(REG_LEN, 24'd0);
		settle();
		queue_sample(16'sh7fff, FADE_PLAIN);
		queue_sample(16'sh8000, FADE_OUT);
		settle();
		write_reg(REG_LEN, 24'd481);
		settle();
		queue_sample(16'sh5555, FADE_IN);
		settle();
		write_reg(REG_LEN, 24'd511);
		settle();
		queue_sample(-16'sd21846, FADE_UNDEF);
		settle();

		// single-sample frame
		write_reg(REG_B0, 24'h100000);
		write_reg(REG_B1, 24'h0c0000);
		write_reg(REG_B2, 24'h100000);
		write_reg(REG_A1, 24'hf80000);
		write_reg(REG_A2, 24'h040000);
		write_reg(REG_LEN, 24'd1);
		settle();
		queue_sample(16'sd20000, FADE_IN);
		queue_sample(-16'sd20000, FADE_OUT);
		settle();

		// fade-in stays dry through mid-frame
		write_reg(REG_LEN, 24'd5);
		settle();
		queue_sample(16'sd20000, FADE_IN);
		queue_sample(-16'sd15000, FADE_IN);
		queue_sample(16'sd10000, FADE_IN);
		queue_sample(-16'sd5000, FADE_IN);
		queue_sample(16'sd30000, FADE_IN);
		settle();

		load_filter(1'b1, LEN_W'(MAX_FRAME));
		queue_random(65);
		settle();
		load_filter(1'b0, LEN_W'(1));
		queue_random(65);
		settle();
		load_filter(1'b1, LEN_W'($urandom_range(2, 40)));
		queue_random(65);
		settle();

		send_idle_pct = 87;
		recv_idle_pct = 25;
		load_filter(1'b1, LEN_W'($urandom_range(1, MAX_FRAME)));
		queue_random(65);
		settle();
		load_filter(1'b1, LEN_W'($urandom_range(MAX_FRAME + 1, 511)));
		queue_random(15);
		settle();
		write_reg(REG_LEN, 24'd0);
		settle();
		queue_random(10);
		settle();
		load_filter(1'b0, LEN_W'($urandom_range(16, 64)));
		queue_random(65);
		settle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_filter(1'b1, LEN_W'($urandom_range(3, 30)));
		hold_go = 1'b1;
		queue_random(65);
		settle();
		load_filter(1'b1, LEN_W'(MAX_FRAME));
		queue_random(65);
		settle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && filtered_q.size() == 0)
			$display("biquad_notch_with_crossfade regression: pass");
		else
			$display("biquad_notch_with_crossfade regression: fail");
		$finish;
	end

endmodule
